// File: hw/rtl/uri_percent_decoder_assert.svh
// Assertion macros used by the checker file of the URI percent-decoder.
`ifndef URI_PERCENT_DECODER_ASSERT_SVH
`define URI_PERCENT_DECODER_ASSERT_SVH

// Property that is checked only while reset is released.
`define UPD_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that is checked at every edge, reset included.
`define UPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/updec_pkg.sv
// Package of the URI percent-decoder: types, character constants and the hex digit helper.
package updec_pkg;

    localparam logic [7:0] C_PERCENT = 8'h25;
    localparam logic [7:0] C_PLUS    = 8'h2B;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_NUL     = 8'h00;
    localparam logic [7:0] C_DIG_0   = 8'h30;
    localparam logic [7:0] C_DIG_9   = 8'h39;
    localparam logic [7:0] C_UPPER_A = 8'h41;
    localparam logic [7:0] C_UPPER_F = 8'h46;
    localparam logic [7:0] C_LOWER_A = 8'h61;
    localparam logic [7:0] C_LOWER_F = 8'h66;

    // Most result bytes a single input byte can cause.
    localparam int unsigned MAX_RES = 3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2,
        PH_DROP  = 2'd3
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Result bytes of one input byte; entry 0 leaves first.
    typedef struct packed {
        logic [1:0]                 count;
        logic [MAX_RES-1:0][7:0]    bytes;
        logic [MAX_RES-1:0]         lasts;
    } t_dec_result;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = c[3:0];
        if (c >= C_DIG_0 && c <= C_DIG_9) begin
            h.ok = 1'b1;
        end else if ((c >= C_UPPER_A && c <= C_UPPER_F)
                     || (c >= C_LOWER_A && c <= C_LOWER_F)) begin
            h.ok  = 1'b1;
            h.val = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

// File: hw/rtl/updec_decode.sv
// Escape decoder: phase and held digit registers and the per-byte result logic.
module updec_decode (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [7:0]               i_byte,
    input  logic                     i_last,
    output updec_pkg::t_dec_result   o_res
);

    updec_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_held, n_held;
    updec_pkg::t_hex   w_hex, w_held_hex;

    always_comb begin
        w_hex      = updec_pkg::hex_value(i_byte);
        w_held_hex = updec_pkg::hex_value(r_held);
        o_res      = '0;
        n_phase    = r_phase;
        n_held     = r_held;
        unique case (r_phase)
            updec_pkg::PH_IDLE: begin
                if (i_byte == updec_pkg::C_PERCENT && !i_last) begin
                    n_phase = updec_pkg::PH_PCT;
                end else begin
                    o_res.count    = 2'd1;
                    o_res.bytes[0] = (i_byte == updec_pkg::C_PLUS) ? updec_pkg::C_SPACE
                                                                   : i_byte;
                    o_res.lasts[0] = i_last;
                end
            end
            updec_pkg::PH_PCT: begin
                if (w_hex.ok && !i_last) begin
                    n_held  = i_byte;
                    n_phase = updec_pkg::PH_DIGIT;
                end else if (i_byte == updec_pkg::C_NUL) begin
                    o_res.count    = 2'd1;
                    o_res.bytes[0] = updec_pkg::C_PERCENT;
                    o_res.lasts[0] = 1'b1;
                    n_phase = i_last ? updec_pkg::PH_IDLE : updec_pkg::PH_DROP;
                end else begin
                    o_res.count    = 2'd2;
                    o_res.bytes[0] = updec_pkg::C_PERCENT;
                    o_res.bytes[1] = i_byte;
                    o_res.lasts[1] = i_last;
                    n_phase = updec_pkg::PH_IDLE;
                end
            end
            updec_pkg::PH_DIGIT: begin
                if (w_hex.ok) begin
                    o_res.count    = 2'd1;
                    o_res.bytes[0] = {w_held_hex.val, w_hex.val};
                    o_res.lasts[0] = i_last;
                    n_phase = updec_pkg::PH_IDLE;
                end else if (i_byte == updec_pkg::C_NUL) begin
                    o_res.count    = 2'd2;
                    o_res.bytes[0] = updec_pkg::C_PERCENT;
                    o_res.bytes[1] = r_held;
                    o_res.lasts[1] = 1'b1;
                    n_phase = i_last ? updec_pkg::PH_IDLE : updec_pkg::PH_DROP;
                end else begin
                    o_res.count    = 2'd3;
                    o_res.bytes[0] = updec_pkg::C_PERCENT;
                    o_res.bytes[1] = r_held;
                    o_res.bytes[2] = i_byte;
                    o_res.lasts[2] = i_last;
                    n_phase = updec_pkg::PH_IDLE;
                end
            end
            updec_pkg::PH_DROP: begin
                if (i_last) begin
                    n_phase = updec_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = updec_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= updec_pkg::PH_IDLE;
        end else if (i_fire) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_held <= n_held;
        end
    end

endmodule

// File: hw/rtl/updec_outbuf.sv
// Result register: holds up to three result bytes and hands them out one per cycle while i_ready is high.
module updec_outbuf (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  updec_pkg::t_dec_result   i_res,
    output logic                     o_can_load,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [7:0]               o_byte,
    output logic                     o_last
);

    logic [1:0]                               r_cnt, n_cnt;
    logic [updec_pkg::MAX_RES-1:0][7:0]       r_data, n_data;
    logic [updec_pkg::MAX_RES-1:0]            r_lastb, n_lastb;
    logic                                     w_drain;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_byte     = r_data[0];
    assign o_last     = r_lastb[0];
    assign w_drain    = o_valid && i_ready;
    // Load a new set only when the buffer will be empty after this cycle; the buffer does not enforce it.
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_comb begin
        n_cnt   = r_cnt;
        n_data  = r_data;
        n_lastb = r_lastb;
        if (i_load) begin
            n_cnt   = i_res.count;
            n_data  = i_res.bytes;
            n_lastb = i_res.lasts;
        end else if (w_drain) begin
            n_cnt   = r_cnt - 2'd1;
            n_data  = {8'h00, r_data[updec_pkg::MAX_RES-1:1]};
            n_lastb = {1'b0, r_lastb[updec_pkg::MAX_RES-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_lastb <= n_lastb;
    end

endmodule

// File: hw/rtl/uri_percent_decoder.sv
// Top level of the streaming URI percent-decoder.
//
// The block takes one raw byte of an encoded string per item on the input
// channel (i_in_valid / o_in_ready, with i_in_byte and i_in_last) and gives
// decoded bytes on the output channel (o_out_valid / i_out_ready, with
// o_out_byte and o_out_last). A '+' becomes a space, a well-formed escape
// becomes its byte, and a broken escape is passed on literally; a NUL that
// breaks one ends the output string, and input up to i_in_last is dropped.
// An accepted item lands in the input register; when the result register can
// take it, it is decoded and its zero to three result bytes are loaded there.
// Items that give one result each flow at one item per cycle while the
// receiver is ready. An item that gives two or three results holds the
// result register until all are taken, and the input register then holds
// the next item meanwhile. When the receiver stalls, the result register
// keeps its byte steady and the input register takes at most one further
// item before o_in_ready falls. Reset clears the escape phase and empties
// the input and result registers: no result is shown and the next byte is
// treated as outside an escape.
module uri_percent_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic                    r_in_v;
    logic [7:0]              r_in_byte;
    logic                    r_in_last;
    logic                    w_can_load;
    logic                    w_move;
    logic                    w_accept;
    updec_pkg::t_dec_result  w_res;

    // The held item moves on when the result register will be free.
    assign w_move     = r_in_v && w_can_load;
    assign o_in_ready = !r_in_v || w_move;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_accept) begin
            r_in_v <= 1'b1;
        end else if (w_move) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    updec_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_move),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (w_res)
    );

    updec_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_move),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_byte     (o_out_byte),
        .o_last     (o_out_last)
    );

endmodule

// File: hw/rtl/updec_checker.sv
// Port checker of the URI percent-decoder and its bind to the top level.
`include "uri_percent_decoder_assert.svh"

module updec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_in_byte,
    input logic       i_in_last,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);

    `UPD_ASSERT_RUN(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result item withdrawn before it was taken")
    `UPD_ASSERT_RUN(a_out_payload_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_byte) && $stable(o_out_last), "stalled result item changed")
    `UPD_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result item shown right after reset")
    `UPD_ASSERT_RUN(a_one_item_skid, i_clk, i_rst_n, i_in_valid && o_in_ready && o_out_valid && !i_out_ready |=> i_out_ready || !o_in_ready, "more than one item taken while the receiver stalls")

endmodule

bind uri_percent_decoder updec_checker u_updec_checker (.*);
